/* rtl/core/ttch_pkg.sv */
// Shared constants and types for the tag table command handler.
// No dependencies; used by tag_table_command_handler.
package ttch_pkg;

  // Table capacity and derived widths
  localparam int MAX_TAGS = 32;
  localparam int CNT_W    = 6;
  localparam int IDX_W    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = 8;
  localparam int ENTRY_W  = KEY_W + ADDR_W;

  // Status codes
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_STATION = 4'd2;
  localparam logic [3:0] ST_NODE    = 4'd3;
  localparam logic [3:0] ST_OPCODE  = 4'd4;
  localparam logic [3:0] ST_OPERAND = 4'd5;
  localparam logic [3:0] ST_KEY     = 4'd6;
  localparam logic [3:0] ST_FULL    = 4'd7;
  localparam logic [3:0] ST_ACTION  = 4'd8;

  // Opcodes
  localparam logic [7:0] OP_HELLO  = 8'd0;
  localparam logic [7:0] OP_UPDATE = 8'd2;
  localparam logic [7:0] OP_LIST   = 8'd3;

  // Update actions
  localparam logic [7:0] ACT_DELETE = 8'd0;
  localparam logic [7:0] ACT_ADD    = 8'd1;
  localparam logic [7:0] ACT_CLEAR  = 8'd2;

  // Request length limits: header, header plus delete operand, plus add operand
  localparam logic [7:0] LEN_HDR = 8'd6;
  localparam logic [7:0] LEN_DEL = 8'd11;
  localparam logic [7:0] LEN_ADD = 8'd12;

  // Configuration register indexes and reset values
  localparam logic REG_STATION = 1'b0;
  localparam logic REG_NODE    = 1'b1;
  localparam logic [31:0] STATION_RST = 32'h0001_0203;
  localparam logic [7:0]  NODE_RST    = 8'h00;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
  } entry_t;

endpackage

/* rtl/core/ttch_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ttch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tag_table_command_handler.sv */
// Top level of the tag table command handler: checks, sequencer, output register.
// Depends on ttch_pkg and ttch_ram.
//
// Usage:
//   Requests arrive on the s_ channel, one item per decoded request; results
//   leave on the m_ channel. Every request gives one result item with tlast
//   set, except a valid list, which gives a header item and then one item per
//   stored entry (tuser high), the final one with tlast set.
//   Registers station_id (byte address 0) and node_id (byte address 4) must be
//   written over the APB port while the block is idle (not enforced by the block).
// Flow:
//   One item at a time. A request is taken only in the idle state; the checks
//   are made in the check state, and a simple answer is then loaded into the
//   output register. The table sits in a single RAM with one read port, so each
//   search step is a read then a compare, each compaction move a read then a
//   write, and each listed entry a read then an output item.
// Reset: clears the entry count, the sequencer and the output valid, and
//   restores the register reset values. Table contents are not cleared.
// Stall: a result waits in the output register; the sequencer holds until
//   the register frees, and no new request is taken until the last result
//   of the current one has been loaded.
module tag_table_command_handler (
  input  logic         clk,
  input  logic         rst,
  // fields from bit 0: req_len[7:0], station_in[39:8], node_in[47:40],
  // req_type[55:48], action[63:56], tag_key[95:64], tag_addr[103:96]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,
  // fields from bit 0: status[3:0], addr_out[11:4], zero fill[15:12]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,
  // fields from bit 0: is_entry[0]
  output logic [0:0]   m_tuser,
  output logic         m_tlast,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CNT_W = ttch_pkg::CNT_W;
  localparam int IDX_W = ttch_pkg::IDX_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;
  localparam logic [3:0] S_DWR   = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_LHDR  = 4'd7;
  localparam logic [3:0] S_LRD   = 4'd8;
  localparam logic [3:0] S_LOUT  = 4'd9;

  logic [3:0]  state, state_next;
  logic [31:0] station_id;
  logic [7:0]  node_id;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_inc;
  logic [3:0]  res_status, res_status_next;

  // Latched request fields
  logic [7:0]  req_len, node_in, req_type, action, tag_addr;
  logic [31:0] station_in, tag_key;

  // RAM ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  ttch_pkg::entry_t      ram_wdata, ram_rdata;

  // Output register load
  logic        out_free, out_load;
  logic [3:0]  out_status;
  logic        out_entry, out_last;
  logic [7:0]  out_addr;

  logic cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_id <= ttch_pkg::STATION_RST;
      node_id    <= ttch_pkg::NODE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ttch_pkg::REG_STATION) begin
        station_id <= pwdata;
      end else begin
        node_id <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ttch_pkg::REG_STATION) begin
      prdata = station_id;
    end else begin
      prdata = {24'd0, node_id};
    end
  end

  // Latch an accepted request
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_len    <= s_tdata[7:0];
      station_in <= s_tdata[39:8];
      node_in    <= s_tdata[47:40];
      req_type   <= s_tdata[55:48];
      action     <= s_tdata[63:56];
      tag_key    <= s_tdata[95:64];
      tag_addr   <= s_tdata[103:96];
    end
  end

  // Table storage
  ttch_ram #(
    .WIDTH(ttch_pkg::ENTRY_W),
    .DEPTH(ttch_pkg::MAX_TAGS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign idx_inc   = idx + CNT_W'(1);
  assign out_free  = !m_tvalid || m_tready;
  assign ram_raddr = (state == S_DRD) ? idx_inc[IDX_W-1:0] : idx[IDX_W-1:0];

  // Sequencer
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    idx_next         = idx;
    res_status_next  = res_status;
    ram_we           = 1'b0;
    ram_waddr        = idx[IDX_W-1:0];
    ram_wdata        = ram_rdata;
    out_load         = 1'b0;
    out_status       = res_status;
    out_entry        = 1'b0;
    out_addr         = 8'd0;
    out_last         = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_EMIT;
        idx_next   = '0;
        if (req_len < ttch_pkg::LEN_HDR) begin
          res_status_next = ttch_pkg::ST_SHORT;
        end else if (station_in != station_id) begin
          res_status_next = ttch_pkg::ST_STATION;
        end else if (node_in != node_id) begin
          res_status_next = ttch_pkg::ST_NODE;
        end else if (req_type == ttch_pkg::OP_HELLO) begin
          res_status_next = ttch_pkg::ST_OK;
        end else if (req_type == ttch_pkg::OP_UPDATE) begin
          if (req_len < ttch_pkg::LEN_DEL) begin
            res_status_next = ttch_pkg::ST_OPERAND;
          end else if (action == ttch_pkg::ACT_CLEAR) begin
            entry_count_next = '0;
            res_status_next  = ttch_pkg::ST_OK;
          end else if (action == ttch_pkg::ACT_ADD && req_len < ttch_pkg::LEN_ADD) begin
            res_status_next = ttch_pkg::ST_OPERAND;
          end else if (!(action inside {ttch_pkg::ACT_ADD, ttch_pkg::ACT_DELETE})) begin
            res_status_next = ttch_pkg::ST_ACTION;
          end else begin
            state_next = S_SRD;
          end
        end else if (req_type == ttch_pkg::OP_LIST) begin
          state_next = S_LHDR;
        end else begin
          res_status_next = ttch_pkg::ST_OPCODE;
        end
      end
      // Search: read one entry, then compare it
      S_SRD: begin
        if (idx == entry_count) begin
          state_next = S_EMIT;
          if (action == ttch_pkg::ACT_DELETE) begin
            res_status_next = ttch_pkg::ST_KEY;
          end else if (entry_count >= CNT_W'(ttch_pkg::MAX_TAGS)) begin
            res_status_next = ttch_pkg::ST_FULL;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = entry_count[IDX_W-1:0];
            ram_wdata.key    = tag_key;
            ram_wdata.addr   = tag_addr;
            entry_count_next = entry_count + CNT_W'(1);
            res_status_next  = ttch_pkg::ST_OK;
          end
        end else begin
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (ram_rdata.key == tag_key) begin
          if (action == ttch_pkg::ACT_ADD) begin
            res_status_next = ttch_pkg::ST_KEY;
            state_next      = S_EMIT;
          end else begin
            state_next = S_DRD;
          end
        end else begin
          idx_next   = idx_inc;
          state_next = S_SRD;
        end
      end
      // Compaction: move each later entry forward by one
      S_DRD: begin
        if (idx_inc == entry_count) begin
          entry_count_next = entry_count - CNT_W'(1);
          res_status_next  = ttch_pkg::ST_OK;
          state_next       = S_EMIT;
        end else begin
          state_next = S_DWR;
        end
      end
      S_DWR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[IDX_W-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx_inc;
        state_next = S_DRD;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      // List: header item, then one item per entry
      S_LHDR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = ttch_pkg::ST_OK;
          out_last   = (entry_count == '0);
          state_next = (entry_count == '0) ? S_IDLE : S_LRD;
        end
      end
      S_LRD: begin
        state_next = S_LOUT;
      end
      S_LOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = ttch_pkg::ST_OK;
          out_entry  = 1'b1;
          out_addr   = ram_rdata.addr;
          out_last   = (idx_inc == entry_count);
          idx_next   = idx_inc;
          state_next = (idx_inc == entry_count) ? S_IDLE : S_LRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    res_status <= res_status_next;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= {4'd0, out_addr, out_status};
      m_tuser[0] <= out_entry;
      m_tlast    <= out_last;
    end
  end

`ifndef SYNTHESIS
  // Entry count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ttch_pkg::MAX_TAGS))
    else $error("entry count above capacity");

  // Listed entries always carry ok status
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[3:0] == ttch_pkg::ST_OK)
    else $error("listed entry with error status");

  // An error result closes its request
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] != ttch_pkg::ST_OK |-> m_tlast && !m_tuser[0])
    else $error("error result not final");

  // One request at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");
`endif

endmodule

/* test/tag_table_command_handler_tb.sv */
// Self-checking testbench for tag_table_command_handler: drives requests on the stream
// input and registers over APB, predicts every result item and compares it in order.
// Depends on ttch_pkg and the tag_table_command_handler RTL.
module tag_table_command_handler_tb;

  localparam int IDLE_GAP = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 12;

  // One request item; req_len sits in the lowest bits
  typedef struct packed {
    logic [7:0]  tag_addr;
    logic [31:0] tag_key;
    logic [7:0]  action;
    logic [7:0]  req_type;
    logic [7:0]  node_in;
    logic [31:0] station_in;
    logic [7:0]  req_len;
  } request_t;

  // One result item as seen on the output stream
  typedef struct packed {
    logic [3:0] status;
    logic       is_entry;
    logic [7:0] addr;
    logic       last;
  } answer_t;

  // Mirror of the tag table and the expected answers
  class tag_answer_board;
    logic [31:0] station_id;
    logic [7:0]  node_id;
    int          entry_count;
    logic [31:0] keys [ttch_pkg::MAX_TAGS];
    logic [7:0]  addrs [ttch_pkg::MAX_TAGS];
    answer_t     answers [$];
    int          errors;

    function new();
      station_id  = ttch_pkg::STATION_RST;
      node_id     = ttch_pkg::NODE_RST;
      entry_count = 0;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function void configure(logic idx, logic [31:0] value);
      if (idx == ttch_pkg::REG_STATION) station_id = value;
      else node_id = value[7:0];
    endfunction

    function void push(logic [3:0] st, logic is_entry, logic [7:0] addr, logic last);
      answer_t a;
      a = '{st, is_entry, addr, last};
      answers.push_back(a);
    endfunction

    function int pending();
      return answers.size();
    endfunction

    // Work out the answers of one accepted request and update the table copy
    function void note_request(request_t r);
      logic [3:0] st;
      int hit;
      hit = -1;
      for (int i = 0; i < entry_count; i++)
        if (hit < 0 && keys[i] == r.tag_key) hit = i;
      if (r.req_len < ttch_pkg::LEN_HDR) st = ttch_pkg::ST_SHORT;
      else if (r.station_in != station_id) st = ttch_pkg::ST_STATION;
      else if (r.node_in != node_id) st = ttch_pkg::ST_NODE;
      else if (r.req_type == ttch_pkg::OP_HELLO) st = ttch_pkg::ST_OK;
      else if (r.req_type == ttch_pkg::OP_LIST) begin
        push(ttch_pkg::ST_OK, 1'b0, 8'h00, entry_count == 0);
        for (int i = 0; i < entry_count; i++)
          push(ttch_pkg::ST_OK, 1'b1, addrs[i], i + 1 == entry_count);
        return;
      end else if (r.req_type == ttch_pkg::OP_UPDATE) begin
        if (r.req_len < ttch_pkg::LEN_DEL) st = ttch_pkg::ST_OPERAND;
        else if (r.action == ttch_pkg::ACT_DELETE) begin
          if (hit < 0) st = ttch_pkg::ST_KEY;
          else begin
            // compact the later entries forward
            for (int i = hit + 1; i < entry_count; i++) begin
              keys[i-1]  = keys[i];
              addrs[i-1] = addrs[i];
            end
            entry_count--;
            st = ttch_pkg::ST_OK;
          end
        end else if (r.action == ttch_pkg::ACT_ADD) begin
          if (r.req_len < ttch_pkg::LEN_ADD) st = ttch_pkg::ST_OPERAND;
          else if (hit >= 0) st = ttch_pkg::ST_KEY;
          else if (entry_count >= ttch_pkg::MAX_TAGS) st = ttch_pkg::ST_FULL;
          else begin
            keys[entry_count]  = r.tag_key;
            addrs[entry_count] = r.tag_addr;
            entry_count++;
            st = ttch_pkg::ST_OK;
          end
        end else if (r.action == ttch_pkg::ACT_CLEAR) begin
          entry_count = 0;
          st = ttch_pkg::ST_OK;
        end else st = ttch_pkg::ST_ACTION;
      end else st = ttch_pkg::ST_OPCODE;
      push(st, 1'b0, 8'h00, 1'b1);
    endfunction

    // Compare one accepted result with the oldest expectation
    task check_result(answer_t got);
      answer_t want;
      if (answers.size() == 0) begin
        report($sformatf("unexpected result status=%0d entry=%0b addr=%02h last=%0b",
                         got.status, got.is_entry, got.addr, got.last));
        return;
      end
      want = answers.pop_front();
      if (got !== want)
        report($sformatf("result status=%0d entry=%0b addr=%02h last=%0b, want %0d %0b %02h %0b",
                         got.status, got.is_entry, got.addr, got.last,
                         want.status, want.is_entry, want.addr, want.last));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  tag_answer_board board = new();
  logic [31:0] key_pool [16];
  bit          tx_on = 1'b0;
  bit          tx_steady = 1'b0;
  int          hold_ask = 0;

  tag_table_command_handler i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    return tx_steady ? 0 : pick_gap();
  endfunction

  // Request addressed to this node under the current settings
  function automatic request_t build_request(logic [7:0] len, logic [7:0] op, logic [7:0] act,
                                             logic [31:0] key, logic [7:0] addr);
    request_t r;
    r = '{addr, key, act, op, board.node_id, board.station_id, len};
    return r;
  endfunction

  // Mostly well-formed requests on a small key pool, some broken ones, some noise
  function automatic request_t rand_request();
    request_t r;
    int kind, w;
    logic [7:0] op, act, len;
    logic [31:0] key;
    logic [127:0] noise;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      r = noise[103:0];
      return r;
    end
    len = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(12, 255)) :
                                         8'($urandom_range(6, 11));
    w = $urandom_range(0, 99);
    if (w < 10) op = ttch_pkg::OP_HELLO;
    else if (w < 70) op = ttch_pkg::OP_UPDATE;
    else if (w < 90) op = ttch_pkg::OP_LIST;
    else op = 8'($urandom_range(0, 255));
    w = $urandom_range(0, 99);
    if (w < 45) act = ttch_pkg::ACT_ADD;
    else if (w < 80) act = ttch_pkg::ACT_DELETE;
    else if (w < 85) act = ttch_pkg::ACT_CLEAR;
    else act = 8'($urandom_range(3, 255));
    key = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 15)] : $urandom;
    r = build_request(len, op, act, key, 8'($urandom_range(0, 255)));
    if (kind < 15) begin
      // break the header in one place
      w = $urandom_range(0, 2);
      if (w == 0) r.station_in = r.station_in ^ (32'h1 << $urandom_range(0, 31));
      else if (w == 1) r.node_in = r.node_in ^ (8'h1 << $urandom_range(0, 7));
      else r.req_len = 8'($urandom_range(0, 5));
    end
    return r;
  endfunction

  // Offer one item, note it at acceptance, then idle for gap cycles
  task automatic offer_request(request_t r, int gap);
    s_tdata <= r;
    if (!tx_on) begin
      s_tvalid <= 1'b1;
      tx_on = 1'b1;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(r);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      tx_on = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_idle();
    if (tx_on) begin
      s_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
    while (board.pending() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then release the bus
  task automatic reg_write(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.configure(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: check accepted items, stall at random, honor long hold-offs
  initial begin : result_sink
    int gap_left, hold_left, hold_seen, cycle;
    answer_t got;
    gap_left = 0;
    hold_left = 0;
    hold_seen = 0;
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (!rst && m_tvalid && m_tready) begin
        got = '{m_tdata[3:0], m_tuser[0], m_tdata[11:4], m_tlast};
        board.check_result(got);
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        // leave stretches with no stalls at all
        if ((cycle / 150) % 4 != 0) gap_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [31:0] base;
    int wait_cycles;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0]  = 32'h0000_0000;
    key_pool[15] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset settings
    offer_request(build_request(8'd0, ttch_pkg::OP_HELLO, ttch_pkg::ACT_DELETE, 32'h0, 8'h00),
                  tx_gap());
    offer_request(build_request(8'd5, ttch_pkg::OP_HELLO, ttch_pkg::ACT_DELETE, 32'h0, 8'h00),
                  tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_HELLO, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00) ^ (104'h1 << 8), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_HELLO, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00) ^ (104'h1 << 40), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_HELLO, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, 8'd1, ttch_pkg::ACT_DELETE, 32'h0, 8'h00),
                  tx_gap());
    offer_request(build_request(8'd255, 8'd255, ttch_pkg::ACT_DELETE, 32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_DEL - 8'd1, ttch_pkg::OP_UPDATE,
                                ttch_pkg::ACT_DELETE, 32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_DEL, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(8'd255, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                32'hFFFF_FFFF, 8'hFF), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                32'h0, 8'h5A), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_DEL, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_DELETE,
                                32'h1234_5678, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, 8'd255, 32'h0, 8'h00),
                  tx_gap());
    offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, 8'd3, 32'h0, 8'h00),
                  tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_DEL, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_DEL, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_CLEAR,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                32'hFFFF_FFFF, 8'h3C), tx_gap());
    offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                32'h0, 8'h00), tx_gap());

    // Phases: all-ones settings, all-zeros settings, random settings
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      if (p == 0) begin
        reg_write(ttch_pkg::REG_STATION, 32'hFFFF_FFFF);
        reg_write(ttch_pkg::REG_NODE, 32'h0000_00FF);
      end else if (p == 1) begin
        reg_write(ttch_pkg::REG_STATION, 32'h0000_0000);
        reg_write(ttch_pkg::REG_NODE, 32'h0000_0000);
      end else begin
        reg_write(ttch_pkg::REG_STATION, $urandom);
        reg_write(ttch_pkg::REG_NODE, $urandom_range(0, 255));
      end
      tx_steady = (p == 1);

      // Fill the table past capacity, then list and compact it
      base = $urandom;
      offer_request(build_request(ttch_pkg::LEN_DEL, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_CLEAR,
                                  32'h0, 8'h00), tx_gap());
      for (int i = 0; i < ttch_pkg::MAX_TAGS + 2; i++)
        offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                    base + i, 8'($urandom_range(0, 255))), tx_gap());
      // hold the receiver off while requests keep coming
      if (p == 0) hold_ask <= hold_ask + 1;
      offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                  32'h0, 8'h00), 0);
      offer_request(build_request(ttch_pkg::LEN_DEL, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_DELETE,
                                  base, 8'h00), 0);
      offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                  32'h0, 8'h00), 0);
      offer_request(build_request(ttch_pkg::LEN_ADD, ttch_pkg::OP_UPDATE, ttch_pkg::ACT_ADD,
                                  base + ttch_pkg::MAX_TAGS, 8'h77), 0);
      offer_request(build_request(ttch_pkg::LEN_HDR, ttch_pkg::OP_LIST, ttch_pkg::ACT_DELETE,
                                  32'h0, 8'h00), tx_gap());

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 1 && n == RANDOM_PER_PHASE / 2) wait_idle();
        offer_request(rand_request(), tx_gap());
      end
    end

    // Drain, then let any stray result show up
    if (tx_on) begin
      s_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
    wait_cycles = 0;
    while (board.pending() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4 * ttch_pkg::MAX_TAGS + 20) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
